[sv/adr_pkg.sv]
package adr_pkg;

    localparam int AXES      = 3;
    localparam int IN_W      = 16;
    localparam int FILT_W    = 32;
    localparam int STATE_W   = 48;
    localparam int COEF_W    = 16;
    localparam int FRAC_BITS = 16;
    localparam int BLEN_W    = 5;
    localparam int CFG_W     = 16;
    localparam int OUT_W     = 32;

    typedef logic [1:0] cfg_index_t;

    localparam cfg_index_t CFG_BLOCK_LEN = 2'd0;
    localparam cfg_index_t CFG_HP_ALPHA  = 2'd1;
    localparam cfg_index_t CFG_STEP_TIME = 2'd2;

    localparam logic [BLEN_W-1:0] BLOCK_LEN_RST = 5'd5;
    localparam logic [COEF_W-1:0] HP_ALPHA_RST  = 16'd25289;
    localparam logic [COEF_W-1:0] STEP_TIME_RST = 16'd3277;

    typedef struct packed {
        logic signed [IN_W-1:0] accel_x;
        logic signed [IN_W-1:0] accel_y;
        logic signed [IN_W-1:0] accel_z;
    } in_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] pos_x;
        logic signed [OUT_W-1:0] pos_y;
        logic signed [OUT_W-1:0] pos_z;
        logic                    updated;
    } out_t;

endpackage

[sv/adr_div.sv]
module adr_div #(
    parameter int SUM_W = 20,
    parameter int CNT_W = 5
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [SUM_W-1:0]             sum [adr_pkg::AXES],
    input  logic        [CNT_W-1:0]             n,
    output logic                                done,
    output logic signed [adr_pkg::FILT_W-1:0]   avg [adr_pkg::AXES]
);

    localparam int AXES    = adr_pkg::AXES;
    localparam int FRAC    = adr_pkg::FRAC_BITS;
    localparam int FILT_W  = adr_pkg::FILT_W;
    localparam int STEP    = 4;
    localparam int DIV_CYC = (SUM_W + FRAC + 1 + STEP - 1) / STEP;
    localparam int DIV_P   = DIV_CYC * STEP;
    localparam int CYC_W   = $clog2(DIV_CYC);

    localparam logic signed [FILT_W-1:0] MAX_V = {1'b0, {(FILT_W-1){1'b1}}};
    localparam logic signed [FILT_W-1:0] MIN_V = {1'b1, {(FILT_W-1){1'b0}}};
    localparam logic [DIV_P-1:0]         NEG_LIM = {{(DIV_P-FILT_W){1'b0}}, MIN_V};

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CYC_W-1:0]     cnt_reg, cnt_next;
    logic [DIV_P-1:0]     num_reg [AXES];
    logic [DIV_P-1:0]     num_next [AXES];
    logic [CNT_W-1:0]     rem_reg [AXES];
    logic [CNT_W-1:0]     rem_next [AXES];
    logic                 neg_reg [AXES];
    logic                 neg_next [AXES];

    always_comb
    begin
        logic [CNT_W-1:0] r;
        logic [DIV_P-1:0] q;
        logic [CNT_W:0]   t;
        logic [SUM_W-1:0] mag;
        r = '0;
        q = '0;
        t = '0;
        mag = '0;
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = busy_reg && (cnt_reg == CYC_W'(DIV_CYC - 1));
        num_next  = num_reg;
        rem_next  = rem_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            for (int l = 0; l < AXES; l++)
            begin
                neg_next[l] = sum[l][SUM_W-1];
                mag = sum[l][SUM_W-1] ? SUM_W'(-sum[l]) : SUM_W'(sum[l]);
                num_next[l] = DIV_P'({mag, {FRAC{1'b0}}});
                rem_next[l] = '0;
            end
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CYC_W'(DIV_CYC - 1))
            begin
                busy_next = 1'b0;
            end
            for (int l = 0; l < AXES; l++)
            begin
                r = rem_reg[l];
                q = num_reg[l];
                for (int k = 0; k < STEP; k++)
                begin
                    t = {r, q[DIV_P-1]};
                    q = {q[DIV_P-2:0], 1'b0};
                    if (t >= {1'b0, n})
                    begin
                        t = t - {1'b0, n};
                        q[0] = 1'b1;
                    end
                    r = t[CNT_W-1:0];
                end
                rem_next[l] = r;
                num_next[l] = q;
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < AXES; l++)
        begin
            if (neg_reg[l])
            begin
                if (num_reg[l] > NEG_LIM)
                begin
                    avg[l] = MIN_V;
                end
                else
                begin
                    avg[l] = -$signed(num_reg[l][FILT_W-1:0]);
                end
            end
            else
            begin
                if (|num_reg[l][DIV_P-1:FILT_W-1])
                begin
                    avg[l] = MAX_V;
                end
                else
                begin
                    avg[l] = $signed(num_reg[l][FILT_W-1:0]);
                end
            end
        end
    end

    assign done = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
    end

endmodule

[sv/accel_dead_reckoning_core.sv]
// Dead reckoning from three-axis linear acceleration.
// Each input request carries one acceleration sample in cm/s^2 on in_data and is
// taken when in_valid is high and in_stall is low. Every request returns one result
// on out_data with the current position in whole cm and an updated flag.
// Samples are summed until block_len of them have arrived; the averaged block then
// passes a high-pass filter and is integrated twice into velocity and position.
// A request that does not close a block goes from acceptance to the output state,
// which waits while a stalled receiver holds the last result, and back to idle.
// A request that closes a block runs a divider that retires four quotient bits a
// cycle, then one shared multiplier serves the multiply steps among eight steps per axis.
// in_stall stays high while a request is being worked on.
// The result sits in an output register; a new request is accepted while it waits,
// and a stalled receiver only holds back the hand-off of the next result.
// Reset clears sums, filter history, velocity and position, and loads the default
// configuration. Configuration is written through cfg_we, cfg_index and cfg_data;
// the user must write it only while the block is idle; the block does not enforce it.
module accel_dead_reckoning_core #(
    parameter int MAX_BLOCK = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  adr_pkg::in_t                    in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output adr_pkg::out_t                   out_data,
    input  logic                            cfg_we,
    input  adr_pkg::cfg_index_t             cfg_index,
    input  logic [adr_pkg::CFG_W-1:0]       cfg_data
);

    localparam int AXES      = adr_pkg::AXES;
    localparam int IN_W      = adr_pkg::IN_W;
    localparam int FILT_W    = adr_pkg::FILT_W;
    localparam int STATE_W   = adr_pkg::STATE_W;
    localparam int COEF_W    = adr_pkg::COEF_W;
    localparam int FRAC_BITS = adr_pkg::FRAC_BITS;
    localparam int BLEN_W    = adr_pkg::BLEN_W;
    localparam int OUT_W     = adr_pkg::OUT_W;
    localparam int BLEN_MAX  = (1 << BLEN_W) - 1;
    localparam int NMAX      = (MAX_BLOCK < BLEN_MAX) ? MAX_BLOCK : BLEN_MAX;
    localparam int CNT_W     = $clog2(NMAX + 1);
    localparam int SUM_W     = IN_W + $clog2(NMAX);
    localparam int MA_W      = FILT_W + 2;
    localparam int MB_W      = COEF_W + 1;
    localparam int MUL_W     = MA_W + MB_W;
    localparam int SH_W      = MUL_W - COEF_W;
    localparam int VLO_W     = STATE_W / 2;
    localparam int LO_W      = VLO_W + COEF_W;
    localparam int TOT_W     = MUL_W + VLO_W - 9;
    localparam int DP_W      = TOT_W - COEF_W;
    localparam int ACC_W     = STATE_W + 3;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_DIV   = 11'b000_0000_0010,
        S_FMUL  = 11'b000_0000_0100,
        S_FSAT  = 11'b000_0000_1000,
        S_VMUL  = 11'b000_0001_0000,
        S_VACC  = 11'b000_0010_0000,
        S_PLMUL = 11'b000_0100_0000,
        S_PHMUL = 11'b000_1000_0000,
        S_PSUM  = 11'b001_0000_0000,
        S_PACC  = 11'b010_0000_0000,
        S_OUT   = 11'b100_0000_0000
    } state_t;

    function automatic logic signed [FILT_W-1:0] sat_filt(input logic signed [SH_W-1:0] v);
        logic signed [FILT_W-1:0] r;
        if (v[SH_W-1:FILT_W-1] != {(SH_W - FILT_W + 1){v[SH_W-1]}})
        begin
            r = v[SH_W-1] ? {1'b1, {(FILT_W-1){1'b0}}} : {1'b0, {(FILT_W-1){1'b1}}};
        end
        else
        begin
            r = v[FILT_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [ACC_W-1:0] v);
        logic signed [STATE_W-1:0] r;
        if (v[ACC_W-1:STATE_W-1] != {(ACC_W - STATE_W + 1){v[ACC_W-1]}})
        begin
            r = v[ACC_W-1] ? {1'b1, {(STATE_W-1){1'b0}}} : {1'b0, {(STATE_W-1){1'b1}}};
        end
        else
        begin
            r = v[STATE_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [OUT_W-1:0] whole_cm(input logic signed [STATE_W-1:0] p);
        logic signed [OUT_W-1:0] r;
        r = $signed(p[STATE_W-1:FRAC_BITS])
            + $signed({{(OUT_W-1){1'b0}}, p[STATE_W-1] & (|p[FRAC_BITS-1:0])});
        return r;
    endfunction

    state_t                      state_reg, state_next;
    logic [1:0]                  axis_reg, axis_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic signed [SUM_W-1:0]     sum_reg [AXES];
    logic signed [SUM_W-1:0]     sum_next [AXES];
    logic signed [SUM_W-1:0]     sum_new [AXES];
    logic signed [FILT_W-1:0]    avg_reg [AXES];
    logic signed [FILT_W-1:0]    avg_next [AXES];
    logic signed [FILT_W-1:0]    hp_in_reg [AXES];
    logic signed [FILT_W-1:0]    hp_in_next [AXES];
    logic signed [FILT_W-1:0]    hp_out_reg [AXES];
    logic signed [FILT_W-1:0]    hp_out_next [AXES];
    logic signed [STATE_W-1:0]   vel_reg [AXES];
    logic signed [STATE_W-1:0]   vel_next [AXES];
    logic signed [STATE_W-1:0]   pos_reg [AXES];
    logic signed [STATE_W-1:0]   pos_next [AXES];
    logic signed [MUL_W-1:0]     prod_reg, prod_next;
    logic [LO_W-1:0]             lo_reg, lo_next;
    logic signed [DP_W-1:0]      dp_reg, dp_next;
    logic                        done_reg, done_next;
    logic                        out_valid_reg, out_valid_next;
    adr_pkg::out_t               out_data_reg, out_data_next;
    logic [BLEN_W-1:0]           block_len_reg, block_len_next;
    logic [COEF_W-1:0]           alpha_reg, alpha_next;
    logic [COEF_W-1:0]           step_reg, step_next;

    logic signed [IN_W-1:0]      acc_in [AXES];
    logic [CNT_W-1:0]            n_eff;
    logic [CNT_W-1:0]            count_inc;
    logic signed [MA_W-1:0]      mul_a;
    logic signed [MB_W-1:0]      mul_b;
    logic signed [MUL_W-1:0]     mul_p;
    logic signed [TOT_W-1:0]     total;
    logic                        div_start;
    logic                        div_done;
    logic signed [FILT_W-1:0]    div_avg [AXES];

    adr_div #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .sum   (sum_new),
        .n     (n_eff),
        .done  (div_done),
        .avg   (div_avg)
    );

    assign acc_in[0] = in_data.accel_x;
    assign acc_in[1] = in_data.accel_y;
    assign acc_in[2] = in_data.accel_z;

    always_comb
    begin
        if (block_len_reg == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (block_len_reg > BLEN_W'(NMAX))
        begin
            n_eff = CNT_W'(NMAX);
        end
        else
        begin
            n_eff = CNT_W'(block_len_reg);
        end
    end

    assign count_inc = count_reg + 1'b1;

    always_comb
    begin
        for (int l = 0; l < AXES; l++)
        begin
            sum_new[l] = sum_reg[l] + SUM_W'(acc_in[l]);
        end
    end

    always_comb
    begin
        case (state_reg)
            S_FMUL:
            begin
                mul_a = MA_W'(hp_out_reg[axis_reg]) + MA_W'(avg_reg[axis_reg])
                        - MA_W'(hp_in_reg[axis_reg]);
                mul_b = $signed({1'b0, alpha_reg});
            end
            S_VMUL:
            begin
                mul_a = MA_W'(hp_out_reg[axis_reg]);
                mul_b = $signed({1'b0, step_reg});
            end
            S_PLMUL:
            begin
                mul_a = $signed({{(MA_W-VLO_W){1'b0}}, vel_reg[axis_reg][VLO_W-1:0]});
                mul_b = $signed({1'b0, step_reg});
            end
            S_PHMUL:
            begin
                mul_a = MA_W'($signed(vel_reg[axis_reg][STATE_W-1:VLO_W]));
                mul_b = $signed({1'b0, step_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = MUL_W'(mul_a) * MUL_W'(mul_b);
    assign total = (TOT_W'(prod_reg) <<< VLO_W) + $signed(TOT_W'(lo_reg));

    always_comb
    begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        avg_next       = avg_reg;
        hp_in_next     = hp_in_reg;
        hp_out_next    = hp_out_reg;
        vel_next       = vel_reg;
        pos_next       = pos_reg;
        prod_next      = prod_reg;
        lo_next        = lo_reg;
        dp_next        = dp_reg;
        done_next      = done_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        div_start      = 1'b0;
        block_len_next = block_len_reg;
        alpha_next     = alpha_reg;
        step_next      = step_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                adr_pkg::CFG_BLOCK_LEN: block_len_next = cfg_data[BLEN_W-1:0];
                adr_pkg::CFG_HP_ALPHA:  alpha_next = cfg_data[COEF_W-1:0];
                adr_pkg::CFG_STEP_TIME: step_next = cfg_data[COEF_W-1:0];
                default:
                begin
                end
            endcase
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (count_inc >= n_eff)
                    begin
                        div_start  = 1'b1;
                        done_next  = 1'b1;
                        count_next = '0;
                        for (int l = 0; l < AXES; l++)
                        begin
                            sum_next[l] = '0;
                        end
                        state_next = S_DIV;
                    end
                    else
                    begin
                        done_next  = 1'b0;
                        count_next = count_inc;
                        sum_next   = sum_new;
                        state_next = S_OUT;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    avg_next   = div_avg;
                    axis_next  = '0;
                    state_next = S_FMUL;
                end
            end
            S_FMUL:
            begin
                prod_next  = mul_p;
                state_next = S_FSAT;
            end
            S_FSAT:
            begin
                hp_in_next[axis_reg]  = avg_reg[axis_reg];
                hp_out_next[axis_reg] = sat_filt(prod_reg[MUL_W-1:COEF_W]);
                state_next = S_VMUL;
            end
            S_VMUL:
            begin
                prod_next  = mul_p;
                state_next = S_VACC;
            end
            S_VACC:
            begin
                vel_next[axis_reg] = sat_state(ACC_W'(vel_reg[axis_reg])
                                     + ACC_W'($signed(prod_reg[MUL_W-1:COEF_W])));
                state_next = S_PLMUL;
            end
            S_PLMUL:
            begin
                prod_next  = mul_p;
                state_next = S_PHMUL;
            end
            S_PHMUL:
            begin
                lo_next    = prod_reg[LO_W-1:0];
                prod_next  = mul_p;
                state_next = S_PSUM;
            end
            S_PSUM:
            begin
                dp_next    = total[TOT_W-1:COEF_W];
                state_next = S_PACC;
            end
            S_PACC:
            begin
                pos_next[axis_reg] = sat_state(ACC_W'(pos_reg[axis_reg]) + ACC_W'(dp_reg));
                if (axis_reg == 2'(AXES - 1))
                begin
                    axis_next  = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = S_FMUL;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_data_next.pos_x   = whole_cm(pos_reg[0]);
                    out_data_next.pos_y   = whole_cm(pos_reg[1]);
                    out_data_next.pos_z   = whole_cm(pos_reg[2]);
                    out_data_next.updated = done_reg;
                    out_valid_next        = 1'b1;
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            axis_reg      <= '0;
            count_reg     <= '0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            block_len_reg <= adr_pkg::BLOCK_LEN_RST;
            alpha_reg     <= adr_pkg::HP_ALPHA_RST;
            step_reg      <= adr_pkg::STEP_TIME_RST;
            for (int l = 0; l < AXES; l++)
            begin
                sum_reg[l]    <= '0;
                hp_in_reg[l]  <= '0;
                hp_out_reg[l] <= '0;
                vel_reg[l]    <= '0;
                pos_reg[l]    <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            count_reg     <= count_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
            block_len_reg <= block_len_next;
            alpha_reg     <= alpha_next;
            step_reg      <= step_next;
            sum_reg       <= sum_next;
            hp_in_reg     <= hp_in_next;
            hp_out_reg    <= hp_out_next;
            vel_reg       <= vel_next;
            pos_reg       <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        avg_reg      <= avg_next;
        prod_reg     <= prod_next;
        lo_reg       <= lo_next;
        dp_reg       <= dp_next;
        out_data_reg <= out_data_next;
    end

    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("A result appeared without passing through the output state.");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < CNT_W'(NMAX))
        else $error("The sample count reached the block limit without clearing.");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("The divider finished while the sequencer was not waiting for it.");

    a_updated_clears: assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(out_valid_reg) && out_data_reg.updated) |-> (count_reg == '0))
        else $error("An updated result was given while the block count was not cleared.");

endmodule

[tb/sv/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int AXES      = adr_pkg::AXES;
    localparam int IN_W      = adr_pkg::IN_W;
    localparam int FILT_W    = adr_pkg::FILT_W;
    localparam int STATE_W   = adr_pkg::STATE_W;
    localparam int COEF_W    = adr_pkg::COEF_W;
    localparam int FRAC_BITS = adr_pkg::FRAC_BITS;
    localparam int BLEN_W    = adr_pkg::BLEN_W;
    localparam int CFG_W     = adr_pkg::CFG_W;
    localparam int OUT_W     = adr_pkg::OUT_W;

    localparam int MAX_BLOCK     = 16;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 200;

    localparam adr_pkg::cfg_index_t CFG_SPARE = 2'd3;

    localparam logic signed [IN_W-1:0] ACCEL_MAX = 16'sh7FFF;
    localparam logic signed [IN_W-1:0] ACCEL_MIN = 16'sh8000;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    adr_pkg::in_t         in_data   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    adr_pkg::out_t        out_data;
    logic                 cfg_we    = 1'b0;
    adr_pkg::cfg_index_t  cfg_index = adr_pkg::CFG_BLOCK_LEN;
    logic [CFG_W-1:0]     cfg_data  = '0;

    accel_dead_reckoning_core #(
        .MAX_BLOCK(MAX_BLOCK)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Shadow copy of the block's configuration and integration state.
    logic [BLEN_W-1:0]         blk_len  = adr_pkg::BLOCK_LEN_RST;
    logic [COEF_W-1:0]         alpha_q  = adr_pkg::HP_ALPHA_RST;
    logic [COEF_W-1:0]         dt_q     = adr_pkg::STEP_TIME_RST;
    logic [BLEN_W-1:0]         samp_cnt = '0;
    logic signed [19:0]        acc_sum [AXES] = '{default: '0};
    logic signed [FILT_W-1:0]  hp_in   [AXES] = '{default: '0};
    logic signed [FILT_W-1:0]  hp_out  [AXES] = '{default: '0};
    logic signed [STATE_W-1:0] vel     [AXES] = '{default: '0};
    logic signed [STATE_W-1:0] pos     [AXES] = '{default: '0};

    adr_pkg::in_t  sample_queue [$];
    adr_pkg::out_t pos_expect [$];
    int unsigned outstanding = 0;
    int unsigned mismatches  = 0;
    int unsigned cycles      = 0;
    int unsigned send_idle   = 0;
    int unsigned recv_idle   = 0;

    function automatic longint clamp(longint v, int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
        begin
            return hi;
        end
        if (v < lo)
        begin
            return lo;
        end
        return v;
    endfunction

    function automatic adr_pkg::out_t reckon(adr_pkg::in_t s);
        logic signed [IN_W-1:0]  a [AXES];
        logic signed [OUT_W-1:0] w [AXES];
        longint n;
        longint al;
        longint st;
        longint tmp;
        longint avg;
        longint diff;
        longint filt;
        longint nv;
        longint np;
        longint whole;
        logic   done;
        adr_pkg::out_t r;
        a[0] = s.accel_x;
        a[1] = s.accel_y;
        a[2] = s.accel_z;
        n = longint'(blk_len);
        if (n < 1)
        begin
            n = 1;
        end
        if (n > MAX_BLOCK)
        begin
            n = MAX_BLOCK;
        end
        al = longint'(alpha_q);
        st = longint'(dt_q);
        for (int i = 0; i < AXES; i++)
        begin
            acc_sum[i] = acc_sum[i] + a[i];
        end
        samp_cnt = samp_cnt + 1'b1;
        done = (longint'(samp_cnt) >= n);
        if (done)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                tmp = acc_sum[i];
                avg = clamp((tmp <<< FRAC_BITS) / n, FILT_W);
                diff = longint'(hp_out[i]) + avg - longint'(hp_in[i]);
                filt = clamp((diff * al) >>> COEF_W, FILT_W);
                hp_in[i] = avg[FILT_W-1:0];
                hp_out[i] = filt[FILT_W-1:0];
                nv = clamp(longint'(vel[i]) + ((filt * st) >>> COEF_W), STATE_W);
                vel[i] = nv[STATE_W-1:0];
                np = clamp(longint'(pos[i]) + ((nv * st) >>> COEF_W), STATE_W);
                pos[i] = np[STATE_W-1:0];
                acc_sum[i] = '0;
            end
            samp_cnt = '0;
        end
        for (int i = 0; i < AXES; i++)
        begin
            whole = clamp(longint'(pos[i]) / (longint'(1) <<< FRAC_BITS), OUT_W);
            w[i] = whole[OUT_W-1:0];
        end
        r.pos_x = w[0];
        r.pos_y = w[1];
        r.pos_z = w[2];
        r.updated = done;
        return r;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic check_position(adr_pkg::out_t got);
        adr_pkg::out_t want;
        if (pos_expect.size() == 0)
        begin
            report("result without a pending request", got.pos_x, 0);
            return;
        end
        want = pos_expect.pop_front();
        outstanding--;
        if (got.pos_x !== want.pos_x)
        begin
            report("pos_x", got.pos_x, want.pos_x);
        end
        if (got.pos_y !== want.pos_y)
        begin
            report("pos_y", got.pos_y, want.pos_y);
        end
        if (got.pos_z !== want.pos_z)
        begin
            report("pos_z", got.pos_z, want.pos_z);
        end
        if (got.updated !== want.updated)
        begin
            report("updated", got.updated, want.updated);
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                pos_expect.insert(pos_expect.size(), reckon(in_data));
            end
            if (!in_valid || !in_stall)
            begin
                if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle)
                begin
                    in_valid <= 1'b1;
                    in_data <= sample_queue.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                check_position(out_data);
            end
            out_stall <= ($urandom_range(99) < recv_idle);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic signed [IN_W-1:0] rand_accel();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(9))
            0: return ACCEL_MAX;
            1: return ACCEL_MIN;
            2, 3: return {{(IN_W-8){1'b0}}, r[7:0]} - 16'd128;
            default: return r[IN_W-1:0];
        endcase
    endfunction

    function automatic logic signed [IN_W-1:0] rail_accel(logic high);
        logic [31:0] r;
        r = $urandom_range(700);
        return high ? ACCEL_MAX - r[IN_W-1:0] : ACCEL_MIN + r[IN_W-1:0];
    endfunction

    task automatic queue_sample(logic signed [IN_W-1:0] x, logic signed [IN_W-1:0] y,
                                logic signed [IN_W-1:0] z);
        adr_pkg::in_t s;
        s.accel_x = x;
        s.accel_y = y;
        s.accel_z = z;
        sample_queue.insert(sample_queue.size(), s);
        outstanding++;
    endtask

    task automatic queue_random(int unsigned count);
        for (int unsigned k = 0; k < count; k++)
        begin
            queue_sample(rand_accel(), rand_accel(), rand_accel());
        end
    endtask

    task automatic write_reg(adr_pkg::cfg_index_t idx, logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            adr_pkg::CFG_BLOCK_LEN: blk_len = val[BLEN_W-1:0];
            adr_pkg::CFG_HP_ALPHA:  alpha_q = val;
            adr_pkg::CFG_STEP_TIME: dt_q = val;
            default: ;
        endcase
    endtask

    // Registers change only once every request has returned its result.
    task automatic reconfigure(logic [CFG_W-1:0] bl, logic [CFG_W-1:0] al,
                               logic [CFG_W-1:0] st);
        logic [31:0] junk;
        junk = $urandom;
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        write_reg(adr_pkg::CFG_BLOCK_LEN, bl);
        write_reg(adr_pkg::CFG_HP_ALPHA, al);
        write_reg(adr_pkg::CFG_STEP_TIME, st);
        write_reg(CFG_SPARE, junk[CFG_W-1:0]);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        logic [31:0] r;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        send_idle = 34;
        recv_idle = 84;
        for (int k = 0; k < 5; k++)
        begin
            queue_sample(ACCEL_MAX, ACCEL_MIN, 16'sd0);
        end
        for (int k = 0; k < 5; k++)
        begin
            queue_sample(ACCEL_MIN, ACCEL_MAX, -16'sd1);
        end
        for (int k = 0; k < 5; k++)
        begin
            queue_sample(16'sd1, 16'sd0, ACCEL_MAX);
        end
        for (int k = 0; k < 5; k++)
        begin
            queue_sample(rand_accel(), rand_accel(), ACCEL_MIN);
        end

        // One full block with a zero filter gain and zero step, then ten requests
        // left waiting in an unfinished block.
        reconfigure(16'd16, 16'd0, 16'd0);
        queue_random(16);
        for (int k = 0; k < 10; k++)
        begin
            queue_sample(ACCEL_MAX, ACCEL_MAX, ACCEL_MAX);
        end

        // Shortening the block now closes it on the next request, and the large
        // sum overflows the average.
        reconfigure(16'd2, 16'd40000, 16'd30000);
        queue_sample(ACCEL_MAX, ACCEL_MAX, ACCEL_MAX);
        queue_random(330);

        send_idle = 84;
        recv_idle = 34;
        r = $urandom;
        reconfigure(16'hFFE0, r[15:0], r[31:16]);
        queue_random(100);
        r = $urandom;
        reconfigure(16'($urandom_range(3, 15)), r[15:0], r[31:16]);
        queue_random(150);
        r = $urandom;
        reconfigure(16'd31, r[15:0], r[31:16]);
        queue_random(150);

        // Full gain and step with inputs held near the rails drive the filter and
        // the position into saturation.
        send_idle = 0;
        recv_idle = 0;
        reconfigure(16'd1, 16'hFFFF, 16'hFFFF);
        queue_sample(ACCEL_MAX, ACCEL_MIN, ACCEL_MAX);
        queue_sample(ACCEL_MIN, ACCEL_MAX, ACCEL_MIN);
        for (int k = 0; k < 380; k++)
        begin
            queue_sample(rail_accel(1'b1), rail_accel(1'b0), rand_accel());
        end

        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
